/* rtl/btps_pkg.sv */
// Package for the buzzer tone pattern sequencer.
// Holds field widths, command codes, register indexes and register reset values.
// No dependencies.
package btps_pkg;

  // Field widths
  localparam int TIME_W    = 32;  // millisecond time and durations
  localparam int FREQ_W    = 16;  // tone frequency in Hz
  localparam int MS_W      = 16;  // configured step durations
  localparam int CYC_W     = 18;  // cycle length, up to three step durations
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int STEPS     = 3;   // step slots of a pattern
  localparam int STEP_IDX_W = 2;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_TONE  = 3'd1;
  localparam logic [OP_W-1:0] OP_TRIAD = 3'd2;
  localparam logic [OP_W-1:0] OP_ALARM = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIAD_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LO_HZ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HI_HZ = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_MS    = 3'd5;

  // Register reset values
  localparam logic [MS_W-1:0]   RST_SINGLE_MS   = 16'd100;
  localparam logic [MS_W-1:0]   RST_TRIAD_MS    = 16'd120;
  localparam logic [FREQ_W-1:0] RST_ALARM_LO_HZ = 16'd2000;
  localparam logic [FREQ_W-1:0] RST_ALARM_HI_HZ = 16'd3000;
  localparam logic [MS_W-1:0]   RST_ALARM_MS    = 16'd250;

endpackage

/* rtl/buzzer_tone_pattern_sequencer.sv */
// Buzzer tone pattern sequencer: command items in, one frequency result per item.
// A single subtractor under a small sequencer does the elapsed time, the end test,
// the modulo by the cycle length and the step search. Depends on btps_pkg.
//
//  Port group | Dir | Payload
//  -----------+-----+------------------------------------------------------------
//  in_*       | in  | tuser: opcode; tdata: now_ms, tone_a/b/c_hz, alarm_duration_ms
//  out_*      | out | tdata: tone_hz, playing
//  cfg_*      | in  | register index and write data, one write per cycle
//
// A tick that reaches the step search goes through the elapsed time, the end test,
// a restoring remainder for a repeating alarm and up to two step compares, all on
// the shared 32-bit subtractor. Items that skip the subtractor go straight to the result state.
// Reset is synchronous and active low; there is no clearing pass.
// The block takes one item at a time; a result waiting on out_tready holds the next.
module buzzer_tone_pattern_sequencer
  import btps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Command input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [OP_W-1:0]      in_tuser,   // [2:0] opcode
  input  logic [111:0]         in_tdata,   // [31:0] now_ms, [47:32] tone_a_hz,
                                           // [63:48] tone_b_hz, [79:64] tone_c_hz,
                                           // [111:80] alarm_duration_ms
  // Result output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [15:0] tone_hz, [16] playing, [23:17] zero
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int DIV_CNT_W = $clog2(TIME_W);

  typedef enum logic [2:0] {
    S_IDLE, S_ELAP, S_CMP, S_DIV, S_SEL, S_DONE
  } state_t;

  // Configuration registers
  logic              enabled_r;
  logic [MS_W-1:0]   single_ms_r;
  logic [MS_W-1:0]   triad_ms_r;
  logic [FREQ_W-1:0] alarm_lo_r;
  logic [FREQ_W-1:0] alarm_hi_r;
  logic [MS_W-1:0]   alarm_ms_r;

  // Pattern state
  logic [FREQ_W-1:0]     step_freq_r [STEPS];
  logic [MS_W-1:0]       step_len_r  [STEPS];
  logic [STEP_IDX_W-1:0] step_total_r;
  logic [TIME_W-1:0]     start_time_r;
  logic [TIME_W-1:0]     plen_r;
  logic [CYC_W-1:0]      cyc_r;
  logic                  repeating_r;
  logic                  alarm_mode_r;
  logic                  active_r;

  // Sequencer and working registers
  state_t                state_r;
  logic [TIME_W-1:0]     work_r;
  logic [TIME_W-1:0]     pos_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [STEP_IDX_W-1:0] idx_r;
  logic [FREQ_W-1:0]     tone_r;
  logic                  out_valid_r;
  logic [FREQ_W-1:0]     out_tone_r;
  logic                  out_play_r;

  // Shared subtractor
  logic [TIME_W-1:0]     alu_a;
  logic [TIME_W-1:0]     alu_b;
  logic [TIME_W:0]       alu_diff;
  logic                  alu_borrow;

  logic                  in_fire;
  logic                  blocked;
  logic [CYC_W-1:0]      triad_total;
  logic [TIME_W-1:0]     in_now;
  logic [FREQ_W-1:0]     in_fa;
  logic [FREQ_W-1:0]     in_fb;
  logic [FREQ_W-1:0]     in_fc;
  logic [TIME_W-1:0]     in_dur;
  logic [STEP_IDX_W-1:0] last_idx;

  assign in_now = in_tdata[31:0];
  assign in_fa  = in_tdata[47:32];
  assign in_fb  = in_tdata[63:48];
  assign in_fc  = in_tdata[79:64];
  assign in_dur = in_tdata[111:80];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_play_r, out_tone_r};

  assign blocked     = !enabled_r || (active_r && alarm_mode_r);
  assign triad_total = {1'b0, triad_ms_r, 1'b0} + {2'b00, triad_ms_r};
  assign last_idx    = step_total_r - 2'd1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b1;
      single_ms_r <= RST_SINGLE_MS;
      triad_ms_r  <= RST_TRIAD_MS;
      alarm_lo_r  <= RST_ALARM_LO_HZ;
      alarm_hi_r  <= RST_ALARM_HI_HZ;
      alarm_ms_r  <= RST_ALARM_MS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ENABLED:     enabled_r   <= cfg_wdata[0];
        REG_SINGLE_MS:   single_ms_r <= cfg_wdata;
        REG_TRIAD_MS:    triad_ms_r  <= cfg_wdata;
        REG_ALARM_LO_HZ: alarm_lo_r  <= cfg_wdata;
        REG_ALARM_HI_HZ: alarm_hi_r  <= cfg_wdata;
        REG_ALARM_MS:    alarm_ms_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared subtractor, one use per sequencer state
  always_comb begin
    case (state_r)
      S_ELAP: begin
        alu_a = work_r;
        alu_b = start_time_r;
      end
      S_CMP: begin
        alu_a = work_r;
        alu_b = plen_r;
      end
      S_DIV: begin
        alu_a = {pos_r[TIME_W-2:0], work_r[TIME_W-1]};
        alu_b = {{(TIME_W-CYC_W){1'b0}}, cyc_r};
      end
      S_SEL: begin
        alu_a = pos_r;
        alu_b = {{(TIME_W-MS_W){1'b0}}, step_len_r[idx_r]};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[TIME_W];

  // Sequencer, pattern state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_total_r <= '0;
      start_time_r <= '0;
      plen_r       <= '0;
      cyc_r        <= '0;
      repeating_r  <= 1'b0;
      alarm_mode_r <= 1'b0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < STEPS; i++) begin
        step_freq_r[i] <= '0;
        step_len_r[i]  <= '0;
      end
    end else begin
      // A taken result frees the output register unless a new one lands this cycle
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // Take a command; starts and stop update the pattern right here
        S_IDLE: begin
          if (in_fire) begin
            tone_r  <= '0;
            work_r  <= in_now;
            // Only a tick on a running, enabled pattern needs the subtractor
            state_r <= (in_tuser == OP_TICK && enabled_r && active_r) ? S_ELAP : S_DONE;
            case (in_tuser)
              OP_TICK: ;
              OP_TONE: begin
                if (!blocked) begin
                  step_freq_r[0] <= in_fa;
                  step_len_r[0]  <= single_ms_r;
                  step_total_r   <= 2'd1;
                  start_time_r   <= in_now;
                  plen_r         <= {{(TIME_W-MS_W){1'b0}}, single_ms_r};
                  cyc_r          <= {{(CYC_W-MS_W){1'b0}}, single_ms_r};
                  repeating_r    <= 1'b0;
                  alarm_mode_r   <= 1'b0;
                  active_r       <= 1'b1;
                end
              end
              OP_TRIAD: begin
                if (!blocked) begin
                  step_freq_r[0] <= in_fa;
                  step_freq_r[1] <= in_fb;
                  step_freq_r[2] <= in_fc;
                  step_len_r[0]  <= triad_ms_r;
                  step_len_r[1]  <= triad_ms_r;
                  step_len_r[2]  <= triad_ms_r;
                  step_total_r   <= 2'd3;
                  start_time_r   <= in_now;
                  plen_r         <= {{(TIME_W-CYC_W){1'b0}}, triad_total};
                  cyc_r          <= triad_total;
                  repeating_r    <= 1'b0;
                  alarm_mode_r   <= 1'b0;
                  active_r       <= 1'b1;
                end
              end
              OP_ALARM: begin
                if (enabled_r) begin
                  step_freq_r[0] <= alarm_lo_r;
                  step_freq_r[1] <= alarm_hi_r;
                  step_len_r[0]  <= alarm_ms_r;
                  step_len_r[1]  <= alarm_ms_r;
                  step_total_r   <= 2'd2;
                  start_time_r   <= in_now;
                  plen_r         <= in_dur;
                  cyc_r          <= {1'b0, alarm_ms_r, 1'b0};
                  repeating_r    <= 1'b1;
                  alarm_mode_r   <= 1'b1;
                  active_r       <= 1'b1;
                end
              end
              OP_STOP: begin
                active_r     <= 1'b0;
                alarm_mode_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        // Elapsed time, modulo 2^32
        S_ELAP: begin
          work_r  <= alu_diff[TIME_W-1:0];
          state_r <= S_CMP;
        end
        // End of pattern, then choose between remainder and direct search
        S_CMP: begin
          if (!alu_borrow) begin
            active_r     <= 1'b0;
            alarm_mode_r <= 1'b0;
            state_r      <= S_DONE;
          end else if (step_total_r == '0 || cyc_r == '0) begin
            state_r <= S_DONE;
          end else if (repeating_r) begin
            pos_r     <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end else begin
            pos_r   <= work_r;
            idx_r   <= '0;
            state_r <= S_SEL;
          end
        end
        // Restoring remainder, one elapsed bit per cycle
        S_DIV: begin
          pos_r     <= alu_borrow ? alu_a : alu_diff[TIME_W-1:0];
          work_r    <= {work_r[TIME_W-2:0], 1'b0};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_W'(TIME_W - 1)) begin
            idx_r   <= '0;
            state_r <= S_SEL;
          end
        end
        // Step search: subtract each step length until the position falls inside
        S_SEL: begin
          if (idx_r == last_idx || alu_borrow) begin
            tone_r  <= step_freq_r[idx_r];
            state_r <= S_DONE;
          end else begin
            pos_r <= alu_diff[TIME_W-1:0];
            idx_r <= idx_r + 1'b1;
          end
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tone_r  <= tone_r;
            out_play_r  <= active_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The remainder stays below the cycle length throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (pos_r < {{(TIME_W-CYC_W){1'b0}}, cyc_r}))
    else $error("remainder reached the cycle length");

  // A non-tick command produces its result without using the subtractor.
  a_cmd_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser != OP_TICK) |=> (state_r == S_DONE))
    else $error("non-tick command did not go straight to the result");

  // A running alarm is always an active pattern.
  a_alarm_active: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_mode_r |-> active_r)
    else $error("alarm mode set without an active pattern");

  // A pattern ends only by a stop, by its end test or by reset.
  a_end_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> ($past(state_r == S_CMP) || $past(!rst_n) ||
                         $past(in_fire && in_tuser == OP_STOP)))
    else $error("pattern ended without a cause");

  // The step search never runs past the last step of the pattern.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL) |-> (idx_r <= last_idx))
    else $error("step search ran past the last step");
`endif

endmodule

/* tb/tone_sequence_checker.sv */
// Result checker for the buzzer tone pattern sequencer testbench.
// Watches the command, result and register-write ports, keeps its own pattern state
// and compares every result with the expected tone. Depends on btps_pkg.
`timescale 1ns / 1ps
module tone_sequence_checker
  import btps_pkg::*;
#(
  parameter int IN_DATA_W  = 112,
  parameter int OUT_DATA_W = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OP_W-1:0]       in_tuser,   // [2:0] opcode
  input  logic [IN_DATA_W-1:0]  in_tdata,   // now_ms, tone_a_hz, tone_b_hz, tone_c_hz,
                                            // alarm_duration_ms
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // tone_hz, playing, zero padding
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen
);

  typedef struct packed {
    logic [FREQ_W-1:0] tone;
    logic              playing;
  } tone_result_t;

  // Register copies.
  logic              en;
  logic [MS_W-1:0]   single_ms;
  logic [MS_W-1:0]   triad_ms;
  logic [FREQ_W-1:0] alarm_lo_hz;
  logic [FREQ_W-1:0] alarm_hi_hz;
  logic [MS_W-1:0]   alarm_ms;

  // Pattern state.
  logic [FREQ_W-1:0]     step_hz [STEPS];
  logic [MS_W-1:0]       step_ms [STEPS];
  logic [STEP_IDX_W-1:0] n_steps;
  logic [TIME_W-1:0]     start_ms;
  logic [TIME_W-1:0]     length_ms;
  logic                  repeats;
  logic                  alarm_on;
  logic                  running;

  tone_result_t expected_tones [$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want, got);
    mismatches++;
  endtask

  // Frequency for a tick; ends the pattern once its length has passed.
  function automatic logic [FREQ_W-1:0] tick_tone(input logic [TIME_W-1:0] now_ms);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] cyc;
    logic [TIME_W-1:0] pos;
    logic [TIME_W-1:0] acc;
    int i;
    if (!en || !running) return '0;
    elapsed = now_ms - start_ms;
    if (elapsed >= length_ms) begin
      running  = 1'b0;
      alarm_on = 1'b0;
      return '0;
    end
    if (n_steps == 0) return '0;
    cyc = '0;
    for (i = 0; i < n_steps; i++) cyc += TIME_W'(step_ms[i]);
    if (cyc == 0) return '0;
    pos = repeats ? elapsed % cyc : elapsed;
    acc = '0;
    for (i = 0; i + 1 < n_steps; i++) begin
      acc += TIME_W'(step_ms[i]);
      if (pos < acc) return step_hz[i];
    end
    return step_hz[n_steps - 1];
  endfunction

  // Applies one command to the pattern state and returns the result it should give.
  function automatic tone_result_t predict_tone(input logic [OP_W-1:0] op,
                                                input logic [IN_DATA_W-1:0] data);
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] dur_ms;
    logic [FREQ_W-1:0] hz_a;
    logic [FREQ_W-1:0] hz_b;
    logic [FREQ_W-1:0] hz_c;
    logic              shut_out;
    tone_result_t      res;
    now_ms = data[0 +: TIME_W];
    hz_a   = data[TIME_W +: FREQ_W];
    hz_b   = data[TIME_W + FREQ_W +: FREQ_W];
    hz_c   = data[TIME_W + 2 * FREQ_W +: FREQ_W];
    dur_ms = data[TIME_W + 3 * FREQ_W +: TIME_W];
    // A disabled block or a running fire alarm keeps tone and three-tone starts out.
    shut_out = !en || (running && alarm_on);
    res.tone = '0;
    case (op)
      OP_TICK: res.tone = tick_tone(now_ms);
      OP_TONE: if (!shut_out) begin
        step_hz[0] = hz_a;
        step_ms[0] = single_ms;
        n_steps    = STEP_IDX_W'(1);
        start_ms   = now_ms;
        length_ms  = TIME_W'(single_ms);
        repeats    = 1'b0;
        alarm_on   = 1'b0;
        running    = 1'b1;
      end
      OP_TRIAD: if (!shut_out) begin
        step_hz[0] = hz_a;
        step_hz[1] = hz_b;
        step_hz[2] = hz_c;
        for (int i = 0; i < STEPS; i++) step_ms[i] = triad_ms;
        n_steps    = STEP_IDX_W'(STEPS);
        start_ms   = now_ms;
        length_ms  = TIME_W'(STEPS) * TIME_W'(triad_ms);
        repeats    = 1'b0;
        alarm_on   = 1'b0;
        running    = 1'b1;
      end
      OP_ALARM: if (en) begin
        step_hz[0] = alarm_lo_hz;
        step_hz[1] = alarm_hi_hz;
        step_ms[0] = alarm_ms;
        step_ms[1] = alarm_ms;
        n_steps    = STEP_IDX_W'(2);
        start_ms   = now_ms;
        length_ms  = dur_ms;
        repeats    = 1'b1;
        alarm_on   = 1'b1;
        running    = 1'b1;
      end
      OP_STOP: begin
        running  = 1'b0;
        alarm_on = 1'b0;
      end
      default: ;
    endcase
    res.playing = running;
    return res;
  endfunction

  // Results are compared before the command of the same edge is queued; a command
  // never finishes in the cycle it is taken.
  always @(posedge clk) begin
    tone_result_t want;
    if (!rst_n) begin
      en          = 1'b1;
      single_ms   = RST_SINGLE_MS;
      triad_ms    = RST_TRIAD_MS;
      alarm_lo_hz = RST_ALARM_LO_HZ;
      alarm_hi_hz = RST_ALARM_HI_HZ;
      alarm_ms    = RST_ALARM_MS;
      for (int i = 0; i < STEPS; i++) begin
        step_hz[i] = '0;
        step_ms[i] = '0;
      end
      n_steps   = '0;
      start_ms  = '0;
      length_ms = '0;
      repeats   = 1'b0;
      alarm_on  = 1'b0;
      running   = 1'b0;
      expected_tones.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tones.size() == 0) begin
          report_mismatch("result with nothing pending", '0, 32'(out_tdata));
        end else begin
          want = expected_tones.pop_front();
          if (out_tdata[FREQ_W-1:0] !== want.tone)
            report_mismatch("tone_hz", 32'(want.tone), 32'(out_tdata[FREQ_W-1:0]));
          if (out_tdata[FREQ_W] !== want.playing)
            report_mismatch("playing", 32'(want.playing), 32'(out_tdata[FREQ_W]));
          if (out_tdata[OUT_DATA_W-1:FREQ_W+1] !== '0)
            report_mismatch("padding", '0, 32'(out_tdata[OUT_DATA_W-1:FREQ_W+1]));
        end
        results_seen++;
      end
      // Register writes keep only the register's width; unknown indexes are dropped.
      if (cfg_we) begin
        case (cfg_addr)
          REG_ENABLED:     en          = cfg_wdata[0];
          REG_SINGLE_MS:   single_ms   = cfg_wdata[MS_W-1:0];
          REG_TRIAD_MS:    triad_ms    = cfg_wdata[MS_W-1:0];
          REG_ALARM_LO_HZ: alarm_lo_hz = cfg_wdata[FREQ_W-1:0];
          REG_ALARM_HI_HZ: alarm_hi_hz = cfg_wdata[FREQ_W-1:0];
          REG_ALARM_MS:    alarm_ms    = cfg_wdata[MS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_tones.push_back(predict_tone(in_tuser, in_tdata));
    end
    outstanding <= expected_tones.size();
  end

endmodule

/* tb/tb_buzzer_tone_pattern_sequencer.sv */
// Top of the buzzer tone pattern sequencer testbench: clock, reset, command and
// register stimulus, output back-pressure and the verdict.
// Depends on btps_pkg, buzzer_tone_pattern_sequencer and tone_sequence_checker.
`timescale 1ns / 1ps
module tb_buzzer_tone_pattern_sequencer;
  import btps_pkg::*;

  localparam int IN_DATA_W     = 2 * TIME_W + 3 * FREQ_W;
  localparam int OUT_DATA_W    = 24;
  localparam int OP_CODES      = 1 << OP_W;
  localparam int REG_SLOTS     = 1 << CFG_IDX_W;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OP_W-1:0]       in_tuser   = '0;   // [2:0] opcode
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [31:0] now_ms, [47:32] tone_a_hz,
                                            // [63:48] tone_b_hz, [79:64] tone_c_hz,
                                            // [111:80] alarm_duration_ms
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [15:0] tone_hz, [16] playing
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata  = '0;

  int mismatches;
  int outstanding;
  int results_seen;

  int   sender_idle_pct = 0;
  int   stall_pct       = 0;
  logic hold_req        = 1'b0;
  logic hold_done       = 1'b0;
  int   hold_count      = 0;
  int   cycle_count     = 0;
  int   commands_sent   = 0;
  int   settings_used   = 0;

  // Running millisecond time and the duration registers as last written.
  logic [TIME_W-1:0] clock_ms      = '0;
  logic [MS_W-1:0]   cur_single_ms = RST_SINGLE_MS;
  logic [MS_W-1:0]   cur_triad_ms  = RST_TRIAD_MS;
  logic [MS_W-1:0]   cur_alarm_ms  = RST_ALARM_MS;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buzzer_tone_pattern_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tone_sequence_checker #(
    .IN_DATA_W  (IN_DATA_W),
    .OUT_DATA_W (OUT_DATA_W)
  ) tone_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Result side: random stalls, or one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
      else hold_count <= hold_count + 1;
    end else begin
      if (!hold_req) begin
        hold_done  <= 1'b0;
        hold_count <= 0;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("buzzer_tone_pattern_sequencer regression: fail");
      $finish;
    end
  end

  // Offers one command and returns at the edge where it is taken. Valid stays high
  // into the next command unless the sender decides to idle first.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_ms,
                          input logic [FREQ_W-1:0] hz_a, hz_b, hz_c,
                          input logic [TIME_W-1:0] dur_ms);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dur_ms, hz_c, hz_b, hz_a, now_ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op <= OP_STOP) commands_sent++;
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] now_ms);
    send_cmd(OP_TICK, now_ms, 16'($urandom()), 16'($urandom()), 16'($urandom()),
             $urandom());
  endtask

  // Any opcode, unused ones included, with random fields.
  task automatic send_noise(input logic [TIME_W-1:0] now_ms);
    send_cmd(OP_W'($urandom_range(OP_CODES - 1)), now_ms, 16'($urandom()),
             16'($urandom()), 16'($urandom()), $urandom());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SINGLE_MS: cur_single_ms = val;
      REG_TRIAD_MS:  cur_triad_ms  = val;
      REG_ALARM_MS:  cur_alarm_ms  = val;
      default: ;
    endcase
  endtask

  // Drops valid, waits for every pending result, then lets the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One pattern start followed by ticks spread over its length, now and then a stray
  // command in between and a tick past the end.
  task automatic play_pattern();
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] dur_ms;
    logic [TIME_W-1:0] cyc;
    logic [TIME_W-1:0] span;
    int n_ticks;
    case ($urandom_range(2))
      0:       op = OP_TONE;
      1:       op = OP_TRIAD;
      default: op = OP_ALARM;
    endcase
    cyc = 8 * TIME_W'(cur_alarm_ms) + 8;
    case ($urandom_range(9))
      0:       dur_ms = $urandom();
      1:       dur_ms = '0;
      2:       dur_ms = '1;
      default: dur_ms = $urandom_range(1, 2 * cyc);
    endcase
    if (op == OP_TONE) span = TIME_W'(cur_single_ms);
    else if (op == OP_TRIAD) span = TIME_W'(STEPS) * TIME_W'(cur_triad_ms);
    else span = (dur_ms < 2 * cyc) ? dur_ms : 2 * cyc;
    send_cmd(op, clock_ms, 16'($urandom()), 16'($urandom()), 16'($urandom()), dur_ms);
    n_ticks = $urandom_range(2, 8);
    repeat (n_ticks) begin
      if ($urandom_range(9) == 0) send_noise(clock_ms);
      clock_ms += $urandom_range(0, span / 4 + 1);
      send_tick(clock_ms);
    end
    if ($urandom_range(2) == 0) begin
      clock_ms += span;
      send_tick(clock_ms);
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = commands_sent + count;
    while (commands_sent < stop_at) begin
      case ($urandom_range(9))
        0:       send_noise($urandom());
        1:       clock_ms = $urandom();
        2:       send_tick(clock_ms);
        default: play_pattern();
      endcase
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing running: a tick, a stop and the unused opcodes all stay silent.
    send_cmd(OP_TICK, '0, '0, '0, '0, '0);
    send_cmd(OP_STOP, '1, '1, '1, '1, '1);
    for (int k = OP_STOP + 1; k < OP_CODES; k++) send_cmd(OP_W'(k), '1, '1, '1, '1, '1);

    // Single tone straddling the 32-bit time wrap, up to its last millisecond and end.
    t = 32'hFFFF_FFC0;
    send_cmd(OP_TONE, t, 16'hFFFF, '0, '0, '0);
    send_tick(t);
    send_tick(t + TIME_W'(cur_single_ms) - 1);
    send_tick(t + TIME_W'(cur_single_ms));

    // Three-tone sequence around its step edges and its end.
    t = 32'h0000_1000;
    send_cmd(OP_TRIAD, t, 16'h0001, 16'h8000, 16'hFFFF, '0);
    send_tick(t + TIME_W'(cur_triad_ms) - 1);
    send_tick(t + TIME_W'(cur_triad_ms));
    send_tick(t + 3 * TIME_W'(cur_triad_ms) - 1);
    send_tick(t + 3 * TIME_W'(cur_triad_ms));

    // Fire alarm: step edges, wrap into a second repeat of the pattern, blocked starts, then its end.
    t = 32'h0002_0000;
    send_cmd(OP_ALARM, t, '0, '0, '0, 32'd1000);
    send_tick(t + 249);
    send_tick(t + 250);
    send_tick(t + 600);
    send_cmd(OP_TONE, t + 700, 16'h1234, '0, '0, '0);
    send_cmd(OP_TRIAD, t + 700, 16'h1111, 16'h2222, 16'h3333, '0);
    send_tick(t + 999);
    send_tick(t + 1000);

    // Zero-length alarm ends on its first tick; the longest one runs until stopped.
    send_cmd(OP_ALARM, t, '0, '0, '0, '0);
    send_tick(t);
    send_cmd(OP_ALARM, t, '0, '0, '0, '1);
    send_tick(t + 32'hFFFF_FFFE);
    send_cmd(OP_STOP, t, '0, '0, '0, '0);
    wait_idle();
    settings_used++;

    // Reset register values, no idling.
    run_random(110);
    wait_idle();

    // Shortest steps and extreme alarm tones, sender idling.
    write_reg(REG_SINGLE_MS, 16'd1);
    write_reg(REG_TRIAD_MS, 16'd1);
    write_reg(REG_ALARM_MS, 16'd1);
    write_reg(REG_ALARM_LO_HZ, '0);
    write_reg(REG_ALARM_HI_HZ, '1);
    settings_used++;
    sender_idle_pct = 62;
    run_random(110);
    wait_idle();

    // Longest steps, receiver stalling.
    write_reg(REG_SINGLE_MS, '1);
    write_reg(REG_TRIAD_MS, '1);
    write_reg(REG_ALARM_MS, '1);
    write_reg(REG_ALARM_LO_HZ, '1);
    write_reg(REG_ALARM_HI_HZ, '0);
    settings_used++;
    sender_idle_pct = 0;
    stall_pct <= 62;
    run_random(110);

    // Disabled with an alarm left running: ticks stay silent, stop still works.
    send_cmd(OP_ALARM, clock_ms, '0, '0, '0, '1);
    wait_idle();
    write_reg(REG_ENABLED, 16'hFFFE);
    settings_used++;
    sender_idle_pct = 26;
    stall_pct <= 26;
    run_random(60);
    wait_idle();

    // Zero durations; upper register bits and unknown indexes are ignored.
    write_reg(REG_ENABLED, 16'hFFFF);
    write_reg(REG_SINGLE_MS, '0);
    write_reg(REG_TRIAD_MS, '0);
    write_reg(REG_ALARM_MS, '0);
    for (int k = REG_ALARM_MS + 1; k < REG_SLOTS; k++)
      write_reg(CFG_IDX_W'(k), CFG_DAT_W'($urandom()));
    settings_used++;
    run_random(110);
    wait_idle();

    // Short random steps; starts with a long output hold while commands keep coming.
    write_reg(REG_SINGLE_MS, MS_W'($urandom_range(1, 40)));
    write_reg(REG_TRIAD_MS, MS_W'($urandom_range(1, 40)));
    write_reg(REG_ALARM_MS, MS_W'($urandom_range(1, 40)));
    write_reg(REG_ALARM_LO_HZ, FREQ_W'($urandom()));
    write_reg(REG_ALARM_HI_HZ, FREQ_W'($urandom()));
    settings_used++;
    hold_req <= 1'b1;
    play_pattern();
    while (!hold_done) @(posedge clk);
    hold_req <= 1'b0;
    run_random(180);
    wait_idle();

    $display("Covered %0d commands under %0d register settings; %0d results checked.",
             commands_sent, settings_used, results_seen);
    $display("Idle mixes on both sides and a %0d-cycle output hold were included.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("buzzer_tone_pattern_sequencer regression: pass");
    end else begin
      $display("buzzer_tone_pattern_sequencer regression: fail");
    end
    $finish;
  end

endmodule

/* buzzer_tone_pattern_sequencer.f */
rtl/btps_pkg.sv
rtl/buzzer_tone_pattern_sequencer.sv
tb/tone_sequence_checker.sv
tb/tb_buzzer_tone_pattern_sequencer.sv
